// ===== rtl/lav_pkg.sv =====
// Shared constants and types for the look-at view matrix pipeline.
// No dependencies; every other rtl file imports this package.
`default_nettype none

package lav_pkg;

	// Fraction bits of the signed fixed-point format on both channels
	localparam int FRAC_BITS = 16;

	// Normalizer: magnitudes are scaled so the largest has NRM_W significant bits
	localparam int NRM_W  = 30;
	localparam int SUM_W  = 2 * NRM_W + 2;
	localparam int ROOT_W = SUM_W / 2;
	localparam int MAG_W  = (2 * FRAC_BITS + 2 > 34) ? 2 * FRAC_BITS + 2 : 34;
	localparam int DIV_N  = FRAC_BITS + 1;

	// Unit vector components hold magnitudes up to 1.0
	localparam int UNIT_W = FRAC_BITS + 2;
	localparam int PROD_W = 2 * UNIT_W;
	localparam int CRS_W  = PROD_W + 1;

	// Group index of the final output transaction of one matrix
	localparam logic [1:0] LAST_GRP = 2'd3;

	typedef struct packed {
		logic signed [31:0] eye_x;
		logic signed [31:0] eye_y;
		logic signed [31:0] eye_z;
		logic signed [31:0] target_x;
		logic signed [31:0] target_y;
		logic signed [31:0] target_z;
		logic signed [31:0] upward_x;
		logic signed [31:0] upward_y;
		logic signed [31:0] upward_z;
	} req_t;

	typedef struct packed {
		logic [1:0]         group_index;
		logic signed [31:0] elem_a;
		logic signed [31:0] elem_b;
		logic signed [31:0] elem_c;
		logic signed [31:0] elem_d;
		logic               degenerate;
		logic               last_group;
	} rsp_t;

	typedef logic [2:0][MAG_W-1:0]  mvec_t;
	typedef logic [2:0][UNIT_W-1:0] uvec_t;

	// Data that rides along the normalizer pipelines
	typedef struct packed {
		logic [2:0][31:0] eye;
		uvec_t            f;
		logic             ok;
	} side_t;

	// Finished matrix, rows in memory order
	typedef struct packed {
		logic [3:0][3:0][31:0] e;
		logic                  ok;
	} mat_t;

endpackage

`default_nettype wire

// ===== rtl/lav_norm.sv =====
// Pipelined vector normalizer: scale, sum of squares, square root, divide.
// Depends on lav_pkg.
`default_nettype none

module lav_norm (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  lav_pkg::mvec_t  mag_i,
	input  logic [2:0]      neg_i,
	input  lav_pkg::side_t  side_i,
	output logic            vld_o,
	output lav_pkg::uvec_t  unit_o,
	output logic            nz_o,
	output lav_pkg::side_t  side_o
);
	import lav_pkg::*;

	localparam int BL_W  = $clog2(MAG_W + 1);
	localparam int REM_W = ROOT_W + 2;

	typedef struct packed {
		logic [2:0][NRM_W-1:0] n;
		logic [2:0]            neg;
		logic                  nz;
		side_t                 side;
	} carry_t;

	// Stage 1: largest magnitude
	logic [MAG_W-1:0] max_c;
	logic             v_s1;
	mvec_t            mag_s1;
	logic [2:0]       neg_s1;
	side_t            side_s1;
	logic [MAG_W-1:0] max_s1;

	always_comb begin
		max_c = mag_i[0];
		if (mag_i[1] > max_c) max_c = mag_i[1];
		if (mag_i[2] > max_c) max_c = mag_i[2];
	end

	// Stage 2: bit length of the largest magnitude
	logic [BL_W-1:0] blen_c;
	logic            v_s2;
	mvec_t           mag_s2;
	logic [2:0]      neg_s2;
	side_t           side_s2;
	logic [BL_W-1:0] blen_s2;
	logic            nz_s2;

	always_comb begin
		blen_c = '0;
		for (int i = 0; i < MAG_W; i++) begin
			if (max_s1[i]) blen_c = BL_W'(i + 1);
		end
	end

	// Stage 3: shift all three by the same amount
	logic [2:0][NRM_W-1:0] nrm_c;
	logic [MAG_W-1:0]      sh_c [3];
	logic                  v_s3;
	carry_t                c_s3;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			if (blen_s2 > BL_W'(NRM_W)) sh_c[i] = mag_s2[i] >> (blen_s2 - BL_W'(NRM_W));
			else sh_c[i] = mag_s2[i] << (BL_W'(NRM_W) - blen_s2);
			nrm_c[i] = sh_c[i][NRM_W-1:0];
		end
	end

	// Stage 4: squares, stage 5: their sum
	logic [2*NRM_W-1:0] sq_c [3];
	logic               v_s4;
	carry_t             c_s4;
	logic [2*NRM_W-1:0] sq_s4 [3];
	logic               v_s5;
	carry_t             c_s5;
	logic [SUM_W-1:0]   sum_s5;

	always_comb begin
		for (int i = 0; i < 3; i++) sq_c[i] = c_s3.n[i] * c_s3.n[i];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1      <= mag_i;
			neg_s1      <= neg_i;
			side_s1     <= side_i;
			max_s1      <= max_c;
			mag_s2      <= mag_s1;
			neg_s2      <= neg_s1;
			side_s2     <= side_s1;
			blen_s2     <= blen_c;
			nz_s2       <= (max_s1 != '0);
			c_s3.n      <= nrm_c;
			c_s3.neg    <= neg_s2;
			c_s3.nz     <= nz_s2;
			c_s3.side   <= side_s2;
			c_s4        <= c_s3;
			sq_s4       <= sq_c;
			c_s5        <= c_s4;
			sum_s5      <= SUM_W'(sq_s4[0]) + SUM_W'(sq_s4[1]) + SUM_W'(sq_s4[2]);
		end
	end

	// Square root: one result bit per stage
	logic              sq_v_s    [ROOT_W];
	logic [SUM_W-1:0]  sq_rad_s  [ROOT_W];
	logic [REM_W-1:0]  sq_rem_s  [ROOT_W];
	logic [ROOT_W-1:0] sq_root_s [ROOT_W];
	carry_t            sq_c_s    [ROOT_W];

	for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
		logic              vin;
		logic [SUM_W-1:0]  rad_in;
		logic [REM_W-1:0]  rem_in;
		logic [ROOT_W-1:0] root_in;
		carry_t            cin;
		logic [REM_W+1:0]  rem_sh;
		logic [REM_W+1:0]  trial;
		logic              take;

		if (k == 0) begin : g_in
			assign vin     = v_s5;
			assign rad_in  = sum_s5;
			assign rem_in  = '0;
			assign root_in = '0;
			assign cin     = c_s5;
		end else begin : g_in
			assign vin     = sq_v_s[k-1];
			assign rad_in  = sq_rad_s[k-1];
			assign rem_in  = sq_rem_s[k-1];
			assign root_in = sq_root_s[k-1];
			assign cin     = sq_c_s[k-1];
		end

		assign rem_sh = {rem_in, rad_in[SUM_W-1 -: 2]};
		assign trial  = (REM_W + 2)'({root_in, 2'b01});
		assign take   = (rem_sh >= trial);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_v_s[k] <= 1'b0;
			else if (en) sq_v_s[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_rad_s[k]  <= {rad_in[SUM_W-3:0], 2'b00};
				sq_rem_s[k]  <= REM_W'(take ? rem_sh - trial : rem_sh);
				sq_root_s[k] <= {root_in[ROOT_W-2:0], take};
				sq_c_s[k]    <= cin;
			end
		end
	end

	// Divide magnitude * 2^FRAC_BITS by the length, one quotient bit per stage
	logic                        dv_v_s   [DIV_N];
	logic [2:0][NRM_W:0]         dv_r_s   [DIV_N];
	logic [2:0][DIV_N-1:0]       dv_q_s   [DIV_N];
	logic [ROOT_W-1:0]           dv_len_s [DIV_N];
	carry_t                      dv_c_s   [DIV_N];

	for (genvar k = 0; k < DIV_N; k++) begin : g_div
		logic                  vin;
		logic [ROOT_W-1:0]     len_in;
		carry_t                cin;
		logic [2:0][NRM_W+1:0] cand;
		logic [2:0][DIV_N-1:0] q_in;
		logic [2:0]            qbit;
		logic [2:0][NRM_W:0]   r_nx;

		if (k == 0) begin : g_in
			assign vin    = sq_v_s[ROOT_W-1];
			assign len_in = sq_root_s[ROOT_W-1];
			assign cin    = sq_c_s[ROOT_W-1];
			assign q_in   = '0;
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign cand[i] = {2'b00, cin.n[i]};
			end
		end else begin : g_in
			assign vin    = dv_v_s[k-1];
			assign len_in = dv_len_s[k-1];
			assign cin    = dv_c_s[k-1];
			assign q_in   = dv_q_s[k-1];
			for (genvar i = 0; i < 3; i++) begin : g_lane
				assign cand[i] = {dv_r_s[k-1][i], 1'b0};
			end
		end

		always_comb begin
			for (int i = 0; i < 3; i++) begin
				qbit[i] = (cand[i] >= {1'b0, len_in});
				r_nx[i] = (NRM_W + 1)'(qbit[i] ? cand[i] - {1'b0, len_in} : cand[i]);
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_v_s[k] <= 1'b0;
			else if (en) dv_v_s[k] <= vin;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_r_s[k]   <= r_nx;
				dv_len_s[k] <= len_in;
				dv_c_s[k]   <= cin;
				for (int i = 0; i < 3; i++) dv_q_s[k][i] <= {q_in[i][DIV_N-2:0], qbit[i]};
			end
		end
	end

	// Reapply signs; a zero vector gives a zero unit vector
	logic [UNIT_W-1:0] uq_c [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			uq_c[i] = UNIT_W'(dv_q_s[DIV_N-1][i]);
			if (!dv_c_s[DIV_N-1].nz) unit_o[i] = '0;
			else if (dv_c_s[DIV_N-1].neg[i]) unit_o[i] = -uq_c[i];
			else unit_o[i] = uq_c[i];
		end
	end

	assign vld_o  = dv_v_s[DIV_N-1];
	assign nz_o   = dv_c_s[DIV_N-1].nz;
	assign side_o = dv_c_s[DIV_N-1].side;

endmodule

`default_nettype wire

// ===== rtl/lav_mat.sv =====
// Back end: true up vector, translation dot products, saturation, matrix layout.
// Depends on lav_pkg.
`default_nettype none

module lav_mat (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            vld_i,
	input  lav_pkg::uvec_t  s_i,
	input  logic            nz_i,
	input  lav_pkg::side_t  side_i,
	output logic            vld_o,
	output lav_pkg::mat_t   mat_o
);
	import lav_pkg::*;

	localparam int UP_W  = FRAC_BITS + 3;
	localparam int DOT_W = FRAC_BITS + 36;
	localparam logic [DOT_W-1:0]        HALF   = DOT_W'(1) << (FRAC_BITS - 1);
	localparam logic signed [DOT_W-1:0] SAT_HI = DOT_W'(32'h7fffffff);
	localparam logic signed [DOT_W-1:0] SAT_LO = ~SAT_HI;
	localparam logic [31:0]             ONE    = 32'd1 << FRAC_BITS;

	typedef struct packed {
		uvec_t            s;
		uvec_t            f;
		logic [2:0][31:0] eye;
		logic             ok;
	} mc_t;

	// Divide by 2^FRAC_BITS, round half away from zero
	function automatic logic signed [DOT_W-1:0] rescale(input logic signed [DOT_W-1:0] v);
		logic [DOT_W-1:0] m;
		m = v[DOT_W-1] ? DOT_W'(-v) : DOT_W'(v);
		m = (m + HALF) >> FRAC_BITS;
		return v[DOT_W-1] ? -$signed(m) : $signed(m);
	endfunction

	function automatic logic [31:0] sat32(input logic signed [DOT_W-1:0] v);
		logic [31:0] r;
		if (v > SAT_HI) r = SAT_HI[31:0];
		else if (v < SAT_LO) r = SAT_LO[31:0];
		else r = v[31:0];
		return r;
	endfunction

	mc_t                      c_in;
	logic signed [PROD_W-1:0] pr_c [6];
	logic                     v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	mc_t                      c_s1, c_s2, c_s3, c_s4, c_s5;
	logic signed [PROD_W-1:0] pr_s1 [6];
	logic signed [CRS_W-1:0]  ur_s2 [3];
	logic [2:0][UP_W-1:0]     u_s3, u_s4, u_s5;
	logic signed [DOT_W-1:0]  dp_c [9];
	logic signed [DOT_W-1:0]  dp_s4 [9];
	logic signed [DOT_W-1:0]  dot_s5 [3];
	mat_t                     mat_c;
	mat_t                     mat_s6;

	assign c_in.s   = s_i;
	assign c_in.f   = side_i.f;
	assign c_in.eye = side_i.eye;
	assign c_in.ok  = side_i.ok & nz_i;

	// Cross product s x f, products first
	always_comb begin
		pr_c[0] = $signed(s_i[1]) * $signed(side_i.f[2]);
		pr_c[1] = $signed(s_i[2]) * $signed(side_i.f[1]);
		pr_c[2] = $signed(s_i[2]) * $signed(side_i.f[0]);
		pr_c[3] = $signed(s_i[0]) * $signed(side_i.f[2]);
		pr_c[4] = $signed(s_i[0]) * $signed(side_i.f[1]);
		pr_c[5] = $signed(s_i[1]) * $signed(side_i.f[0]);
	end

	// Dot products with the eye
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dp_c[i]     = $signed(c_s3.s[i]) * $signed(c_s3.eye[i]);
			dp_c[3 + i] = $signed(u_s3[i]) * $signed(c_s3.eye[i]);
			dp_c[6 + i] = $signed(c_s3.f[i]) * $signed(c_s3.eye[i]);
		end
	end

	// Lay out the matrix
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mat_c.e[i][0] = 32'($signed(c_s5.s[i]));
			mat_c.e[i][1] = 32'($signed(u_s5[i]));
			mat_c.e[i][2] = -(32'($signed(c_s5.f[i])));
			mat_c.e[i][3] = '0;
		end
		mat_c.e[3][0] = sat32(-rescale(dot_s5[0]));
		mat_c.e[3][1] = sat32(-rescale(dot_s5[1]));
		mat_c.e[3][2] = sat32(rescale(dot_s5[2]));
		mat_c.e[3][3] = ONE;
		mat_c.ok      = c_s5.ok;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s1 <= vld_i;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1      <= c_in;
			pr_s1     <= pr_c;
			c_s2      <= c_s1;
			ur_s2[0]  <= CRS_W'(pr_s1[0]) - CRS_W'(pr_s1[1]);
			ur_s2[1]  <= CRS_W'(pr_s1[2]) - CRS_W'(pr_s1[3]);
			ur_s2[2]  <= CRS_W'(pr_s1[4]) - CRS_W'(pr_s1[5]);
			c_s3      <= c_s2;
			for (int i = 0; i < 3; i++) u_s3[i] <= UP_W'(rescale(DOT_W'(ur_s2[i])));
			c_s4      <= c_s3;
			u_s4      <= u_s3;
			dp_s4     <= dp_c;
			c_s5      <= c_s4;
			u_s5      <= u_s4;
			for (int i = 0; i < 3; i++) dot_s5[i] <= dp_s4[3*i] + dp_s4[3*i + 1] + dp_s4[3*i + 2];
			mat_s6    <= mat_c;
		end
	end

	assign vld_o = v_s6;
	assign mat_o = mat_s6;

endmodule

`default_nettype wire

// ===== rtl/lav_ser.sv =====
// Output register: holds one matrix and sends it as four transactions.
// Depends on lav_pkg.
`default_nettype none

module lav_ser (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           ld_i,
	input  lav_pkg::mat_t  mat_i,
	output logic           rdy_o,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lav_pkg::rsp_t  rsp
);
	import lav_pkg::*;

	logic       busy_q;
	logic [1:0] grp_q;
	mat_t       mat_q;

	// Free, or about to send the last group
	assign rdy_o = ~busy_q | (rsp_ready & (grp_q == LAST_GRP));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			grp_q  <= '0;
		end else if (ld_i && rdy_o) begin
			busy_q <= 1'b1;
			grp_q  <= '0;
		end else if (busy_q && rsp_ready) begin
			if (grp_q == LAST_GRP) busy_q <= 1'b0;
			else grp_q <= grp_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_i && rdy_o) mat_q <= mat_i;
	end

	// Drive the current group
	assign rsp_valid       = busy_q;
	assign rsp.group_index = grp_q;
	assign rsp.elem_a      = mat_q.e[grp_q][0];
	assign rsp.elem_b      = mat_q.e[grp_q][1];
	assign rsp.elem_c      = mat_q.e[grp_q][2];
	assign rsp.elem_d      = mat_q.e[grp_q][3];
	assign rsp.degenerate  = ~mat_q.ok;
	assign rsp.last_group  = (grp_q == LAST_GRP);

endmodule

`default_nettype wire

// ===== rtl/look_at_view_matrix.sv =====
// Look-at view matrix builder, top level.
// Depends on lav_pkg, lav_norm, lav_mat and lav_ser.
`default_nettype none

// Each request transaction (eye, target, upward in signed Q16.16) yields four
// response transactions carrying the 4x4 view matrix in memory order, four
// entries each, group_index 0 to 3 and last_group on the fourth. The block is
// one stall-together pipeline: a request is taken in every cycle that the
// pipeline can advance, and the output register, which sends each matrix as
// four transactions, sets the sustained rate. The two chained normalizers make
// up most of the pipeline, each a 31-stage square root followed by a
// FRAC_BITS+1 stage divider. degenerate is set on all four responses when a
// vector to normalize had zero length; translation entries saturate.
module look_at_view_matrix (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  lav_pkg::req_t  req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output lav_pkg::rsp_t  rsp
);
	import lav_pkg::*;

	logic             en;
	logic [2:0][31:0] eye_c, tgt_c, upv_c;
	logic [MAG_W-1:0] dext_c [3];
	logic [MAG_W-1:0] uext_c [3];

	// Input stage
	logic       v_s1;
	mvec_t      dmag_s1, umag_s1;
	logic [2:0] dneg_s1, uneg_s1;
	side_t      side_s1;

	// First normalizers
	logic  v_f, nz_f, nz_u;
	uvec_t f_n, u_n;
	side_t side_f;

	// Cross product f x up
	logic signed [PROD_W-1:0] pr_c [6];
	logic signed [PROD_W-1:0] pr_s2 [6];
	logic                     v_s2, v_s3;
	side_t                    side_s2, side_s3;
	logic signed [CRS_W-1:0]  sr_c [3];
	logic [CRS_W-1:0]         sm_c [3];
	mvec_t                    smag_s3;
	logic [2:0]               sneg_s3;

	// Side normalizer and back end
	logic  v_n2, nz_s;
	uvec_t s_n;
	side_t side_n2;
	logic  v_mat;
	mat_t  mat;
	logic  ser_rdy;

	// Advance whenever the tail is empty or the output register takes it
	assign en        = ~v_mat | ser_rdy;
	assign req_ready = en;

	assign eye_c = {req.eye_z, req.eye_y, req.eye_x};
	assign tgt_c = {req.target_z, req.target_y, req.target_x};
	assign upv_c = {req.upward_z, req.upward_y, req.upward_x};

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			dext_c[i] = MAG_W'($signed(tgt_c[i])) - MAG_W'($signed(eye_c[i]));
			uext_c[i] = MAG_W'($signed(upv_c[i]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s1 <= req_valid;
			v_s2 <= v_f;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				dneg_s1[i] <= dext_c[i][MAG_W-1];
				dmag_s1[i] <= dext_c[i][MAG_W-1] ? -dext_c[i] : dext_c[i];
				uneg_s1[i] <= uext_c[i][MAG_W-1];
				umag_s1[i] <= uext_c[i][MAG_W-1] ? -uext_c[i] : uext_c[i];
			end
			side_s1.eye <= eye_c;
			side_s1.f   <= '0;
			side_s1.ok  <= 1'b1;
		end
	end

	lav_norm u_norm_fwd (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s1),
		.mag_i  (dmag_s1),
		.neg_i  (dneg_s1),
		.side_i (side_s1),
		.vld_o  (v_f),
		.unit_o (f_n),
		.nz_o   (nz_f),
		.side_o (side_f)
	);

	lav_norm u_norm_up (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s1),
		.mag_i  (umag_s1),
		.neg_i  (uneg_s1),
		.side_i (side_s1),
		.vld_o  (),
		.unit_o (u_n),
		.nz_o   (nz_u),
		.side_o ()
	);

	// Products of the side vector
	always_comb begin
		pr_c[0] = $signed(f_n[1]) * $signed(u_n[2]);
		pr_c[1] = $signed(f_n[2]) * $signed(u_n[1]);
		pr_c[2] = $signed(f_n[2]) * $signed(u_n[0]);
		pr_c[3] = $signed(f_n[0]) * $signed(u_n[2]);
		pr_c[4] = $signed(f_n[0]) * $signed(u_n[1]);
		pr_c[5] = $signed(f_n[1]) * $signed(u_n[0]);
	end

	// Differences, split into sign and magnitude
	always_comb begin
		sr_c[0] = CRS_W'(pr_s2[0]) - CRS_W'(pr_s2[1]);
		sr_c[1] = CRS_W'(pr_s2[2]) - CRS_W'(pr_s2[3]);
		sr_c[2] = CRS_W'(pr_s2[4]) - CRS_W'(pr_s2[5]);
		for (int i = 0; i < 3; i++) sm_c[i] = sr_c[i][CRS_W-1] ? CRS_W'(-sr_c[i]) : CRS_W'(sr_c[i]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			pr_s2       <= pr_c;
			side_s2.eye <= side_f.eye;
			side_s2.f   <= f_n;
			side_s2.ok  <= nz_f & nz_u;
			side_s3     <= side_s2;
			for (int i = 0; i < 3; i++) begin
				smag_s3[i] <= MAG_W'(sm_c[i]);
				sneg_s3[i] <= sr_c[i][CRS_W-1];
			end
		end
	end

	lav_norm u_norm_side (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_s3),
		.mag_i  (smag_s3),
		.neg_i  (sneg_s3),
		.side_i (side_s3),
		.vld_o  (v_n2),
		.unit_o (s_n),
		.nz_o   (nz_s),
		.side_o (side_n2)
	);

	lav_mat u_mat (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (en),
		.vld_i  (v_n2),
		.s_i    (s_n),
		.nz_i   (nz_s),
		.side_i (side_n2),
		.vld_o  (v_mat),
		.mat_o  (mat)
	);

	lav_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.ld_i      (v_mat),
		.mat_i     (mat),
		.rdy_o     (ser_rdy),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire
